/* hw/rtl/sth_pkg.sv */
// ----------------------------------------------------------------------------
// sth_pkg: shared constants for the single-to-half converter
// Field widths and magnitude thresholds of the binary32 to binary16 path.
// ----------------------------------------------------------------------------
`default_nettype none
package sth_pkg;
    localparam int SGL_W = 32;
    localparam int HLF_W = 16;
    localparam logic [30:0] MAG_INF         = 31'h7F800000;
    localparam logic [30:0] MAG_OVERFLOW    = 31'h47800000;
    localparam logic [30:0] MAG_MIN_NORMAL  = 31'h38800000;
    localparam logic [30:0] MAG_MIN_SUBNORM = 31'h33000000;
    localparam logic [7:0]  BIAS_GAP        = 8'd112;
    localparam logic [7:0]  SUB_SHIFT_BASE  = 8'd125;
    localparam int PIPE_DEPTH = 3;

    typedef enum logic [4:0] {
        CLS_NAN  = 5'b00001,
        CLS_INF  = 5'b00010,
        CLS_NORM = 5'b00100,
        CLS_SUB  = 5'b01000,
        CLS_ZERO = 5'b10000
    } cls_t;
endpackage
`default_nettype wire

/* hw/rtl/single_to_half_convert_top.sv */
// ----------------------------------------------------------------------------
// single_to_half_convert_top: binary32 to binary16 converter
// Three-stage pipeline: classify, align, round and pack.
// ----------------------------------------------------------------------------
// A request is taken at every edge where start is high; busy is always low,
// so one value enters each cycle. Each result appears on half_bits for
// exactly one cycle with done high, in request order. Each request passes
// through the three register stages of the pipeline, in order: classify,
// alignment with guard and sticky, then round and final pack. Rounding is to
// nearest, ties to even; NaNs keep sign, quiet bit and low payload; overflow
// goes to infinity and magnitudes below 2^-25 flush to signed zero.
`default_nettype none
module single_to_half_convert_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [sth_pkg::SGL_W-1:0] single_bits,
    output logic                           done,
    output logic [sth_pkg::HLF_W-1:0]      half_bits
);
    import sth_pkg::*;

    // stage 1: classify
    logic        vld1_reg;
    logic        sgn1_reg;
    cls_t        cls1_reg;
    logic [30:0] mag1_reg;
    cls_t        cls1_next;
    logic [30:0] mag_in;

    // stage 2: aligned value with guard and sticky
    logic        vld2_reg;
    logic        sgn2_reg;
    cls_t        cls2_reg;
    logic [14:0] v2_reg, v2_next;
    logic        g2_reg, g2_next;
    logic        s2_reg, s2_next;
    logic [9:0]  nan2_reg, nan2_next;

    // stage 3: output
    logic        vld3_reg;
    logic [15:0] res3_reg, res3_next;

    logic [7:0]  exp1;
    logic [4:0]  sh;
    logic [23:0] full;
    logic [23:0] smask;
    logic [15:0] rounded;

    assign busy   = 1'b0;
    assign mag_in = single_bits[30:0];

    always_comb
    begin
        if (mag_in > MAG_INF)              cls1_next = CLS_NAN;
        else if (mag_in >= MAG_OVERFLOW)   cls1_next = CLS_INF;
        else if (mag_in >= MAG_MIN_NORMAL) cls1_next = CLS_NORM;
        else if (mag_in >= MAG_MIN_SUBNORM) cls1_next = CLS_SUB;
        else                               cls1_next = CLS_ZERO;
    end

    // Align: normal drops 13 bits; subnormal shifts by 126 - exponent (14..24).
    always_comb
    begin
        exp1  = mag1_reg[30:23];
        sh    = 5'(SUB_SHIFT_BASE - exp1);
        full  = {1'b1, mag1_reg[22:0]};
        smask = (24'd1 << sh) - 24'd1;
        nan2_next = {mag1_reg[22], mag1_reg[8:0]};
        if (nan2_next == 10'd0)
            nan2_next = 10'd1;
        v2_next = '0;
        g2_next = 1'b0;
        s2_next = 1'b0;
        case (cls1_reg)
            CLS_NORM:
            begin
                v2_next = {5'(exp1 - BIAS_GAP), mag1_reg[22:13]};
                g2_next = mag1_reg[12];
                s2_next = |mag1_reg[11:0];
            end
            CLS_SUB:
            begin
                v2_next = 15'(full >> (sh + 5'd1));
                g2_next = full[sh];
                s2_next = |(full & smask);
            end
            default:
            begin
            end
        endcase
    end

    // Round to nearest even and pack; a carry out of the mantissa bumps the
    // exponent, which reaches infinity naturally.
    always_comb
    begin
        rounded = {1'b0, v2_reg} + 16'(g2_reg & (s2_reg | v2_reg[0]));
        case (cls2_reg)
            CLS_NAN:  res3_next = {sgn2_reg, 5'h1F, nan2_reg};
            CLS_INF:  res3_next = {sgn2_reg, 5'h1F, 10'd0};
            CLS_NORM, CLS_SUB: res3_next = {sgn2_reg, rounded[14:0]};
            default:  res3_next = {sgn2_reg, 15'd0};
        endcase
    end

    // Advance valid bits every cycle; the receiver never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sgn1_reg <= single_bits[31];
        cls1_reg <= cls1_next;
        mag1_reg <= mag_in;
        sgn2_reg <= sgn1_reg;
        cls2_reg <= cls1_reg;
        v2_reg   <= v2_next;
        g2_reg   <= g2_next;
        s2_reg   <= s2_next;
        nan2_reg <= nan2_next;
        res3_reg <= res3_next;
    end

    assign done      = vld3_reg;
    assign half_bits = res3_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done) else $error("result lost");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3)) else $error("result invented");
    a_nan_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld2_reg && cls2_reg == CLS_NAN) |=> (res3_reg[14:10] == 5'h1F
        && res3_reg[9:0] != 10'd0)) else $error("NaN lost");
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld2_reg && cls2_reg == CLS_ZERO) |=> res3_reg[14:0] == 15'd0)
        else $error("flush to zero broken");
endmodule
`default_nettype wire
